@@ rtl/square_matrix_multiply_accumulate_macros.svh @@
// Assertion shorthands shared by smma_ctrl and smma_dp.
`ifndef SQUARE_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SMMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/smma_pkg.sv @@
package smma_pkg;

    localparam int MAX_DIM   = 32;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int FLD_W     = 5;
    localparam int OP_W      = 3;
    localparam int CFG_W     = 6;
    localparam int CFG_RESET = 32;

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SHP_W     = PROD_W - FRAC_BITS;
    // MAX_DIM shifted products plus the old C entry
    localparam int ACC_W     = SHP_W + IDX_W + 1;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_WR_A = 3'd0;
    localparam t_op OP_WR_B = 3'd1;
    localparam t_op OP_WR_C = 3'd2;
    localparam t_op OP_RUN  = 3'd3;
    localparam t_op OP_RD_C = 3'd4;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             wr_c;
        logic             rd_c;
        logic             issue;
        logic             acc_clr;
        logic             store;
        logic             sat_clr;
        logic             out_load;
        logic             out_kind;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_idle;
        logic out_free;
    } t_dp_stat;

    function automatic logic [IDX_W-1:0] fld_idx(input logic [FLD_W-1:0] v);
        return IDX_W'(v);
    endfunction

    function automatic logic fld_inside(input logic [FLD_W-1:0] v);
        return int'(v) < MAX_DIM;
    endfunction

endpackage

@@ rtl/square_matrix_multiply_accumulate.sv @@
// Square fixed-point matrix multiply-accumulate, C := C + A*B, Q16.16 elements.
// Input stream (s_axis): tuser carries the op code (write A, write B, write C,
// run, read C); tdata carries row, column and the element value.
// Output stream (m_axis): tuser says whether the result is a run finish or
// read data of C; tdata carries the C element and the saturation flag.
// Config channel: i_cfg_data sets the matrix size n, which the user must write
// only while idle; the block does not enforce this.
// Writes stream one per cycle while idle. Each memory has one read port; a read
// request fills the C read register on accept, then the output register once
// free. A run issues each C entry's n products to the single MAC, drains, stores.
// Products are floored to Q32.16 and summed exactly; a stored entry saturates.
// The next request is taken once the previous result sits in the output
// register; if the receiver stalls, a request producing a result is still taken
// but waits in the response state until that register empties, blocking writes.
// Reset clears the control state and the saturation flag and sets n to 32;
// the A, B and C stores hold nothing defined until written.
module square_matrix_multiply_accumulate (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // row[4:0], col[9:5], value[41:10], zero pad above
    input  logic [smma_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // op[2:0]
    input  logic [smma_pkg::OP_W-1:0]              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // data[31:0], saturated[32], zero pad above
    output logic [smma_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // kind[0]
    output logic                                   m_axis_tuser,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [smma_pkg::CFG_W-1:0]             i_cfg_data
);
    import smma_pkg::*;

    t_dp_cmd                  cmd;
    t_dp_stat                 stat;
    logic [FLD_W-1:0]         row, col;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] out_data;
    logic                     out_sat;

    assign row   = s_axis_tdata[FLD_W-1:0];
    assign col   = s_axis_tdata[2*FLD_W-1:FLD_W];
    assign value = s_axis_tdata[2*FLD_W+DATA_W-1:2*FLD_W];

    smma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    smma_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_row       (row),
        .i_col       (col),
        .i_value     (value),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser),
        .o_out_data  (out_data),
        .o_out_sat   (out_sat)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, out_sat, out_data};
endmodule

@@ rtl/smma_ctrl.sv @@
`include "square_matrix_multiply_accumulate_macros.svh"

module smma_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  smma_pkg::t_op          i_op,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [smma_pkg::CFG_W-1:0] i_cfg_data,
    output smma_pkg::t_dp_cmd      o_cmd,
    input  smma_pkg::t_dp_stat     i_stat
);
    import smma_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_i, r_j, r_k, r_last;
    logic [CFG_W-1:0]  r_matrix_size;
    logic              r_kind;
    logic              accept;
    logic              run_empty;
    logic [IDX_W-1:0]  run_last;
    logic              elem_last;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign elem_last   = (r_i == r_last) && (r_j == r_last);

    // sizes above MAX_DIM clamp
    always_comb begin
        run_empty = (r_matrix_size == '0);
        if (int'(r_matrix_size) > MAX_DIM) begin
            run_last = IDX_W'(MAX_DIM - 1);
        end else begin
            run_last = IDX_W'(r_matrix_size - 1'b1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_op == OP_RUN) begin
                    n_state = run_empty ? ST_RESP : ST_ISSUE;
                end else if (accept && i_op == OP_RD_C) begin
                    n_state = ST_RESP;
                end
            end
            ST_ISSUE: begin
                if (r_k == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_stat.pipe_idle) begin
                    n_state = elem_last ? ST_RESP : ST_ISSUE;
                end
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_cmd.i = r_i;
        o_cmd.j = r_j;
        o_cmd.k = r_k;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.wr_a    = accept && (i_op == OP_WR_A);
                o_cmd.wr_b    = accept && (i_op == OP_WR_B);
                o_cmd.wr_c    = accept && (i_op == OP_WR_C);
                o_cmd.rd_c    = accept && (i_op == OP_RD_C);
                o_cmd.sat_clr = accept && (i_op == OP_RUN);
            end
            ST_ISSUE: begin
                o_cmd.issue   = 1'b1;
                o_cmd.acc_clr = (r_k == '0);
            end
            ST_DRAIN: begin
                o_cmd.store = i_stat.pipe_idle;
            end
            ST_RESP: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_kind = r_kind;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_matrix_size <= CFG_W'(CFG_RESET);
            r_i           <= '0;
            r_j           <= '0;
            r_k           <= '0;
            r_last        <= '0;
            r_kind        <= KIND_DONE;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_matrix_size <= i_cfg_data;
            end
            if (r_state == ST_IDLE && accept) begin
                r_i    <= '0;
                r_j    <= '0;
                r_k    <= '0;
                r_last <= run_last;
                r_kind <= (i_op == OP_RD_C) ? KIND_READ : KIND_DONE;
            end
            if (r_state == ST_ISSUE) begin
                r_k <= (r_k == r_last) ? '0 : r_k + 1'b1;
            end
            if (r_state == ST_DRAIN && i_stat.pipe_idle) begin
                if (r_j == r_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    `SMMA_ASSERT_IMP(a_store_after_drain, o_cmd.store, i_stat.pipe_idle && !o_cmd.issue,
        "C entry stored while products still in flight")
    `SMMA_ASSERT_IMP(a_load_when_free, o_cmd.out_load, i_stat.out_free,
        "result loaded over an unsent result")
    `SMMA_ASSERT_NXT(a_read_to_resp, accept && i_op == OP_RD_C,
        r_state == ST_RESP && r_kind == KIND_READ, "read request did not reach response")
endmodule

@@ rtl/smma_dp.sv @@
`include "square_matrix_multiply_accumulate_macros.svh"

module smma_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smma_pkg::t_dp_cmd              i_cmd,
    output smma_pkg::t_dp_stat             o_stat,
    input  logic [smma_pkg::FLD_W-1:0]     i_row,
    input  logic [smma_pkg::FLD_W-1:0]     i_col,
    input  logic signed [smma_pkg::DATA_W-1:0] i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_out_kind,
    output logic signed [smma_pkg::DATA_W-1:0] o_out_data,
    output logic                           o_out_sat
);
    import smma_pkg::*;

    logic [DATA_W-1:0] r_mem_a [MEM_DEPTH];
    logic [DATA_W-1:0] r_mem_b [MEM_DEPTH];
    logic [DATA_W-1:0] r_mem_c [MEM_DEPTH];

    logic [ADDR_W-1:0] host_addr, c_waddr, c_raddr;
    logic              in_range, c_we, c_re;
    logic [DATA_W-1:0] c_wdata;

    logic signed [DATA_W-1:0] r_a_q, r_b_q;
    logic [DATA_W-1:0]        r_c_q;
    logic                     r_rd_zero;
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SHP_W-1:0]  shp;
    logic signed [ACC_W-1:0]  r_acc, sum;
    logic                     fits;
    logic [DATA_W-1:0]        sat_val;
    logic                     r_sat;

    assign host_addr = {fld_idx(i_row), fld_idx(i_col)};
    assign in_range  = fld_inside(i_row) && fld_inside(i_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && in_range) begin
            r_mem_a[host_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_a_q <= r_mem_a[{i_cmd.i, i_cmd.k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b && in_range) begin
            r_mem_b[host_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_b_q <= r_mem_b[{i_cmd.k, i_cmd.j}];
        end
    end

    assign c_we    = i_cmd.store || (i_cmd.wr_c && in_range);
    assign c_waddr = i_cmd.store ? {i_cmd.i, i_cmd.j} : host_addr;
    assign c_wdata = i_cmd.store ? sat_val : i_value;
    assign c_re    = i_cmd.rd_c || i_cmd.issue;
    assign c_raddr = i_cmd.rd_c ? host_addr : {i_cmd.i, i_cmd.j};

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem_c[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_c_q <= r_mem_c[c_raddr];
        end
        if (i_cmd.rd_c) begin
            r_rd_zero <= !in_range;
        end
    end

    // read -> multiply -> shift/accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= r_a_q * r_b_q;
        end
    end

    // arithmetic shift: keep the upper bits, floor rounding
    assign shp = r_prod[PROD_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(ACC_W-SHP_W){shp[SHP_W-1]}}, shp};
        end
    end

    assign sum  = r_acc + {{(ACC_W-DATA_W){r_c_q[DATA_W-1]}}, r_c_q};
    assign fits = (&sum[ACC_W-1:DATA_W-1]) || !(|sum[ACC_W-1:DATA_W-1]);

    always_comb begin
        if (fits) begin
            sat_val = sum[DATA_W-1:0];
        end else if (sum[ACC_W-1]) begin
            sat_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.sat_clr) begin
            r_sat <= 1'b0;
        end else if (i_cmd.store && !fits) begin
            r_sat <= 1'b1;
        end
    end

    assign o_stat.pipe_idle = !r_v1 && !r_v2;
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_kind <= i_cmd.out_kind;
            o_out_sat  <= r_sat;
            if (i_cmd.out_kind == KIND_READ && !r_rd_zero) begin
                o_out_data <= r_c_q;
            end else begin
                o_out_data <= '0;
            end
        end
    end

    `SMMA_ASSERT_NXT(a_sat_sticks, i_cmd.store && !fits, r_sat,
        "saturating store did not raise the flag")
    `SMMA_ASSERT_IMP(a_no_clr_midflight, i_cmd.acc_clr, !r_v2 && !r_v1,
        "accumulator cleared with products pending")
endmodule
